// ----- sv/tcgr_pkg.sv -----
package tcgr_pkg;

  // Font geometry
  localparam int GLYPH_ROWS  = 16;
  localparam int GLYPH_COUNT = 256;
  localparam int GLYPH_W     = $clog2(GLYPH_COUNT);
  localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
  localparam int FONT_AW     = $clog2(FONT_DEPTH);

  // Character cell on screen
  localparam int CELL_W    = 8;
  localparam int CELL_H    = 16;
  localparam int ROW_CNT_W = $clog2(CELL_H);

  localparam int ADDR_W  = 48;
  localparam int COORD_W = 14;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;

  // Opcodes
  localparam logic [1:0] OP_LOAD_FONT = 2'd0;
  localparam logic [1:0] OP_PUT_CHAR  = 2'd1;
  localparam logic [1:0] OP_BACKSPACE = 2'd2;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  // Register indexes (byte address 8*i)
  localparam int PADDR_W = 5;
  localparam logic [1:0] REG_BASE_ADDRESS    = 2'd0;
  localparam logic [1:0] REG_SCANLINE_PIXELS = 2'd1;
  localparam logic [1:0] REG_SCREEN_WIDTH    = 2'd2;
  localparam logic [1:0] REG_SCREEN_HEIGHT   = 2'd3;

  localparam logic [COORD_W-1:0] RST_SCANLINE_PIXELS = 14'd1024;
  localparam logic [COORD_W-1:0] RST_SCREEN_WIDTH    = 14'd1024;
  localparam logic [COORD_W-1:0] RST_SCREEN_HEIGHT   = 14'd768;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_BASE,
    ST_ROWS
  } tcgr_state_e;

endpackage

// ----- sv/tcgr_ram.sv -----
module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/text_console_glyph_renderer.sv -----
// Text console glyph renderer.
// Items arrive on the in_* channel (valid/stall): opcode 0 loads one byte of
// the 8x16 font store, opcode 1 puts a character at the cursor, opcode 2 is
// backspace. A drawn or erased cell leaves as sixteen items on the out_*
// channel, top row first, each a framebuffer byte address with an 8-bit mask;
// out_last_row_o marks the sixteenth.
// Font loads, newline and unused opcodes produce no output items. A put or
// backspace runs in steps: accept and update the cursor, the pitch multiply,
// the base add, then sixteen rows, one per cycle while the output register is
// not stalled, read from the font RAM and stepped by one shared 48-bit adder.
// in_stall_o stays high until the last row has entered the output register.
// A stalled output register holds its item and the row sequencer waits.
// Registers sit on an APB-style port at byte addresses 0, 8, 16, 24; pready
// is always high. Reset clears the cursor and restores the register defaults;
// the font store holds garbage until loaded.
module text_console_glyph_renderer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    in_opcode_i,
  input  logic [7:0]                    in_char_code_i,
  input  logic [3:0]                    in_glyph_row_i,
  input  logic [7:0]                    in_font_byte_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tcgr_pkg::ADDR_W-1:0]   out_row_address_o,
  output logic [7:0]                    out_pixel_mask_o,
  output logic                          out_erase_o,
  output logic                          out_below_screen_o,
  output logic                          out_last_row_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcgr_pkg::PADDR_W-1:0]  paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);

  import tcgr_pkg::*;

  tcgr_state_e state_q, state_d;

  logic [ADDR_W-1:0]  base_q;
  logic [COORD_W-1:0] pitch_q, width_q, height_q;

  logic [COORD_W-1:0] cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  logic [COORD_W-1:0] cell_x_q, cell_x_d, cell_y_q, cell_y_d;
  logic               erase_q, erase_d;
  logic [GLYPH_W-1:0] glyph_q, glyph_d;
  logic [ROW_CNT_W-1:0] row_cnt_q, row_cnt_d;
  logic [2*COORD_W+1:0] pix_q;
  logic [ADDR_W-1:0]  addr_q, addr_d;

  logic               out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [7:0]         out_mask_q;
  logic               out_erase_q, out_below_q, out_last_q;

  logic in_accept, draw_item, row_fire, use_base, last_row;
  logic cfg_write;
  logic [1:0] reg_idx;

  logic               font_we;
  logic [FONT_AW-1:0] font_waddr, font_raddr;
  logic [7:0]         font_rdata;
  logic [GLYPH_W-1:0] in_glyph;
  logic [7:0]         row_mask;
  logic               row_below;

  // ------------------------------------------------------------------
  // Configuration port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:3];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      pitch_q  <= RST_SCANLINE_PIXELS;
      width_q  <= RST_SCREEN_WIDTH;
      height_q <= RST_SCREEN_HEIGHT;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_BASE_ADDRESS:    base_q   <= pwdata[ADDR_W-1:0];
        REG_SCANLINE_PIXELS: pitch_q  <= pwdata[COORD_W-1:0];
        REG_SCREEN_WIDTH:    width_q  <= pwdata[COORD_W-1:0];
        REG_SCREEN_HEIGHT:   height_q <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE_ADDRESS:    prdata = 64'(base_q);
      REG_SCANLINE_PIXELS: prdata = 64'(pitch_q);
      REG_SCREEN_WIDTH:    prdata = 64'(width_q);
      REG_SCREEN_HEIGHT:   prdata = 64'(height_q);
      default:             prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Font store
  assign in_glyph   = GLYPH_W'(32'(in_char_code_i) % GLYPH_COUNT);
  assign font_we    = in_accept && (in_opcode_i == OP_LOAD_FONT) &&
                      (32'(in_glyph_row_i) < GLYPH_ROWS);
  assign font_waddr = FONT_AW'(FONT_AW'(in_glyph) * FONT_AW'(GLYPH_ROWS) +
                               FONT_AW'(in_glyph_row_i));
  // Address from the next row count so the data lines up with row_cnt_q.
  assign font_raddr = FONT_AW'(FONT_AW'(glyph_q) * FONT_AW'(GLYPH_ROWS) +
                               FONT_AW'(row_cnt_d));

  tcgr_ram #(
    .WIDTH(8),
    .DEPTH(FONT_DEPTH)
  ) u_font_ram (
    .clk_i  (clk_i),
    .we_i   (font_we),
    .waddr_i(font_waddr),
    .wdata_i(in_font_byte_i),
    .raddr_i(font_raddr),
    .rdata_o(font_rdata)
  );

  // ------------------------------------------------------------------
  // Sequencer
  assign in_accept = in_valid_i && !in_stall_o;
  assign draw_item = ((in_opcode_i == OP_PUT_CHAR) && (in_char_code_i != CHAR_NEWLINE)) ||
                     (in_opcode_i == OP_BACKSPACE);
  assign last_row  = (row_cnt_q == ROW_CNT_W'(CELL_H - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && draw_item) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_BASE;
      ST_BASE: state_d = ST_ROWS;
      ST_ROWS: begin
        if (row_fire && last_row) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    use_base   = 1'b0;
    row_fire   = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_BASE: use_base   = 1'b1;
      ST_ROWS: row_fire   = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ------------------------------------------------------------------
  // Cursor update and cell placement, decided at accept
  always_comb begin
    logic               wrap;
    logic [COORD_W-1:0] y_adv, bs_x, bs_y;
    wrap  = ({1'b0, cursor_x_q} + (COORD_W+1)'(CELL_W)) > {1'b0, width_q};
    y_adv = (cursor_y_q > COORD_MAX - COORD_W'(CELL_H)) ? COORD_MAX :
            cursor_y_q + COORD_W'(CELL_H);
    bs_x  = (cursor_x_q == '0) ? width_q : cursor_x_q;
    bs_y  = (cursor_x_q != '0) ? cursor_y_q :
            (cursor_y_q >= COORD_W'(CELL_H)) ? cursor_y_q - COORD_W'(CELL_H) : '0;

    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    cell_x_d   = cell_x_q;
    cell_y_d   = cell_y_q;
    erase_d    = erase_q;
    glyph_d    = glyph_q;
    if (in_accept) begin
      case (in_opcode_i)
        OP_PUT_CHAR: begin
          if (in_char_code_i == CHAR_NEWLINE) begin
            cursor_x_d = '0;
            cursor_y_d = y_adv;
          end else begin
            cell_x_d   = wrap ? '0 : cursor_x_q;
            cell_y_d   = wrap ? y_adv : cursor_y_q;
            cursor_x_d = cell_x_d + COORD_W'(CELL_W);
            cursor_y_d = cell_y_d;
            erase_d    = 1'b0;
            glyph_d    = in_glyph;
          end
        end
        OP_BACKSPACE: begin
          cell_x_d   = (bs_x >= COORD_W'(CELL_W)) ? bs_x - COORD_W'(CELL_W) : '0;
          cell_y_d   = bs_y;
          cursor_x_d = cell_x_d;
          cursor_y_d = bs_y;
          erase_d    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
    end else begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
    end
  end

  // ------------------------------------------------------------------
  // Row address: multiply once, then step with the shared adder
  always_comb begin
    logic [ADDR_W-1:0] add_a, add_b;
    add_a  = use_base ? base_q : addr_q;
    add_b  = use_base ? ADDR_W'({pix_q, 2'b00}) : ADDR_W'({pitch_q, 2'b00});
    addr_d = addr_q;
    if (use_base || row_fire) begin
      addr_d = add_a + add_b;
    end
  end

  always_comb begin
    row_cnt_d = row_cnt_q;
    if (state_q != ST_ROWS) begin
      row_cnt_d = '0;
    end else if (row_fire) begin
      row_cnt_d = row_cnt_q + ROW_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    cell_x_q  <= cell_x_d;
    cell_y_q  <= cell_y_d;
    erase_q   <= erase_d;
    glyph_q   <= glyph_d;
    addr_q    <= addr_d;
    row_cnt_q <= row_cnt_d;
    if (state_q == ST_MUL) begin
      pix_q <= (2*COORD_W+2)'(cell_x_q) +
               (2*COORD_W+2)'(cell_y_q) * (2*COORD_W+2)'(pitch_q);
    end
  end

  // ------------------------------------------------------------------
  // Output register
  assign row_mask  = erase_q ? 8'hFF :
                     (32'(row_cnt_q) < GLYPH_ROWS) ? font_rdata : 8'h00;
  assign row_below = ({1'b0, cell_y_q} + (COORD_W+1)'(row_cnt_q)) >= {1'b0, height_q};

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (row_fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_fire) begin
      out_addr_q  <= addr_q;
      out_mask_q  <= row_mask;
      out_erase_q <= erase_q;
      out_below_q <= row_below;
      out_last_q  <= last_row;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_row_address_o  = out_addr_q;
  assign out_pixel_mask_o   = out_mask_q;
  assign out_erase_o        = out_erase_q;
  assign out_below_screen_o = out_below_q;
  assign out_last_row_o     = out_last_q;

  // ------------------------------------------------------------------
  // Assertions
  a_draw_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && draw_item |=> state_q == ST_MUL)
    else $error("drawn item did not start the row sequence");

  a_nodraw_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !draw_item |=> state_q == ST_IDLE)
    else $error("item without rows left the sequencer busy");

  a_last_row_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_fire && last_row |=> state_q == ST_IDLE && out_valid_o && out_last_row_o)
    else $error("sixteenth row did not close the cell");

  a_erase_full_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_erase_o |-> out_pixel_mask_o == 8'hFF)
    else $error("erase row without full mask");

  a_rows_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_ROWS)
    else $error("output item outside the row sequence");

endmodule
